// File: rtl/cdn_pkg.sv
// ----------------------------------------------------------------------------
// cdn_pkg
// Shared types, constants and helpers of the Canny direction / NMS unit.
// ----------------------------------------------------------------------------
package cdn_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int PIX_W   = 16;
  localparam int MAG_W   = 31;
  localparam int THR_W   = 16;
  localparam int IMGW_W  = 11;
  localparam int IMGH_W  = 13;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 12;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // 1/(2*sqrt2) as Q0.16
  localparam logic [14:0] DIAG_Q16 = 15'd23170;

  localparam logic [IMGW_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [IMGH_W-1:0] HEIGHT_RST = 13'd480;
  localparam logic [THR_W-1:0]  LOW_RST    = 16'd2560;
  localparam logic [THR_W-1:0]  HIGH_RST   = 16'd7680;
  localparam int                MIN_SIZE   = 5;

  typedef enum logic [1:0] {
    DIR_E  = 2'd0,
    DIR_NE = 2'd1,
    DIR_N  = 2'd2,
    DIR_SE = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_LOW    = 2'd2,
    REG_HIGH   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    dir_t             dir;
    logic [MAG_W-1:0] mag;
  } deriv_t;

  localparam int DERIV_W = $bits(deriv_t);

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic             above_low;
    logic             edge_res;
  } out_item_t;

  function automatic logic [PIX_W-1:0] absdiff(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// File: rtl/cdn_ram.sv
// ----------------------------------------------------------------------------
// cdn_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cdn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/cdn_grad.sv
// ----------------------------------------------------------------------------
// cdn_grad
// Pixel line store, 3x3 pixel window and direction/magnitude selection.
// ----------------------------------------------------------------------------
module cdn_grad #(
  parameter int MAX_WIDTH  = cdn_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = cdn_pkg::MAX_HEIGHT_DEF,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       in_valid,
  input  logic [CW-1:0]              in_col,
  input  logic [RW-1:0]              in_row,
  input  logic [cdn_pkg::PIX_W-1:0]  in_pixel,
  input  logic [CW:0]                w_eff,
  input  logic [RW:0]                h_eff,
  output logic                       out_valid,
  output logic [CW-1:0]              out_col,
  output logic [RW-1:0]              out_row,
  output cdn_pkg::deriv_t            out_deriv
);

  localparam int PW = cdn_pkg::PIX_W;
  localparam int MW = cdn_pkg::MAG_W;

  // stage 1: line store read data
  logic          v1;
  logic [CW-1:0] c1;
  logic [RW-1:0] r1;
  logic [PW-1:0] px1;
  logic          fwd_hit;
  logic [2*PW-1:0] fwd_data;
  logic [2*PW-1:0] ram_rdata;
  logic [2*PW-1:0] line;
  logic [2*PW-1:0] line_wdata;
  logic          ram_we;

  // window, row 0 oldest line, column 2 newest
  logic [PW-1:0] sw [3][3];

  // stage 2
  logic          v2;
  logic [CW-1:0] c2;
  logic [RW-1:0] r2;
  logic          int2;
  logic [PW-1:0] d_e, d_ne, d_n, d_se;
  logic [MW-1:0] ge_c, gne_c, gn_c, gse_c;

  // stage 3
  logic          v3;
  logic [CW-1:0] c3;
  logic [RW-1:0] r3;
  logic          int3;
  logic [MW-1:0] ge, gne, gn, gse;
  cdn_pkg::deriv_t nd;

  assign ram_we     = adv && v1;
  assign line       = fwd_hit ? fwd_data : ram_rdata;
  assign line_wdata = {line[PW-1:0], px1};

  cdn_ram #(.WIDTH(2*PW), .DEPTH(MAX_WIDTH)) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (c1),
    .wdata (line_wdata),
    .re    (adv),
    .raddr (in_col),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
      fwd_hit <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          sw[i][j] <= '0;
        end
      end
    end else if (adv) begin
      v1  <= in_valid;
      c1  <= in_col;
      r1  <= in_row;
      px1 <= in_pixel;
      // same column written back as it is read (frame restart at column 0)
      fwd_hit  <= v1 && in_valid && (c1 == in_col);
      fwd_data <= line_wdata;
      if (v1) begin
        for (int i = 0; i < 3; i++) begin
          sw[i][0] <= sw[i][1];
          sw[i][1] <= sw[i][2];
        end
        sw[0][2] <= line[2*PW-1:PW];
        sw[1][2] <= line[PW-1:0];
        sw[2][2] <= px1;
      end
      v2 <= v1;
      c2 <= c1;
      r2 <= r1;
      v3   <= v2;
      c3   <= c2;
      r3   <= r2;
      int3 <= int2;
      ge   <= ge_c;
      gne  <= gne_c;
      gn   <= gn_c;
      gse  <= gse_c;
      out_valid <= v3;
      out_col   <= c3;
      out_row   <= r3;
      out_deriv <= nd;
    end
  end

  always_comb begin
    int2  = (c2 >= CW'(2)) && (r2 >= RW'(2)) &&
            ({1'b0, c2} < w_eff) && ({1'b0, r2} < h_eff);
    d_e   = cdn_pkg::absdiff(sw[1][2], sw[1][0]);
    d_ne  = cdn_pkg::absdiff(sw[0][2], sw[2][0]);
    d_n   = cdn_pkg::absdiff(sw[0][1], sw[2][1]);
    d_se  = cdn_pkg::absdiff(sw[2][2], sw[0][0]);
    ge_c  = {d_e, 15'b0};
    gn_c  = {d_n, 15'b0};
    gne_c = MW'(d_ne) * MW'(cdn_pkg::DIAG_Q16);
    gse_c = MW'(d_se) * MW'(cdn_pkg::DIAG_Q16);
  end

  // E wins only when strictly largest, then NE, then N, else SE
  always_comb begin
    nd = '0;
    if (int3) begin
      if (ge > gne && ge > gn && ge > gse) begin
        nd.dir = cdn_pkg::DIR_E;
        nd.mag = ge;
      end else if (gne > gn && gne > gse) begin
        nd.dir = cdn_pkg::DIR_NE;
        nd.mag = gne;
      end else if (gn > gse) begin
        nd.dir = cdn_pkg::DIR_N;
        nd.mag = gn;
      end else begin
        nd.dir = cdn_pkg::DIR_SE;
        nd.mag = gse;
      end
    end
  end

endmodule

// File: rtl/cdn_nms.sv
// ----------------------------------------------------------------------------
// cdn_nms
// Derivative line store, 3x3 derivative window, thresholds and suppression.
// ----------------------------------------------------------------------------
module cdn_nms #(
  parameter int MAX_WIDTH  = cdn_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = cdn_pkg::MAX_HEIGHT_DEF,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      in_valid,
  input  logic [CW-1:0]             in_col,
  input  logic [RW-1:0]             in_row,
  input  cdn_pkg::deriv_t           in_deriv,
  input  logic [CW:0]               w_eff,
  input  logic [RW:0]               h_eff,
  input  logic [cdn_pkg::THR_W-1:0] low_thr,
  input  logic [cdn_pkg::THR_W-1:0] high_thr,
  output logic                      res_valid,
  output cdn_pkg::out_item_t        res_item
);

  localparam int DW = cdn_pkg::DERIV_W;
  localparam int MW = cdn_pkg::MAG_W;

  logic            e1v;
  logic [CW-1:0]   e1c;
  logic [RW-1:0]   e1r;
  cdn_pkg::deriv_t e1d;
  logic            fwd_hit;
  logic [2*DW-1:0] fwd_data;
  logic [2*DW-1:0] ram_rdata;
  logic [2*DW-1:0] line;
  logic [2*DW-1:0] line_wdata;
  logic            ram_we;

  cdn_pkg::deriv_t dw [3][3];

  logic            e2v;
  logic [CW-1:0]   e2c;
  logic [RW-1:0]   e2r;

  cdn_pkg::deriv_t ctr;
  logic [MW-1:0]   fwd_mag, bwd_mag;
  logic [MW:0]     v32, lo, hi;
  logic            above;

  assign ram_we     = adv && e1v;
  assign line       = fwd_hit ? fwd_data : ram_rdata;
  assign line_wdata = {line[DW-1:0], e1d};

  cdn_ram #(.WIDTH(2*DW), .DEPTH(MAX_WIDTH)) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (e1c),
    .wdata (line_wdata),
    .re    (adv),
    .raddr (in_col),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      e1v <= 1'b0;
      e2v <= 1'b0;
      fwd_hit <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          dw[i][j] <= '0;
        end
      end
    end else if (adv) begin
      e1v <= in_valid;
      e1c <= in_col;
      e1r <= in_row;
      e1d <= in_deriv;
      fwd_hit  <= e1v && in_valid && (e1c == in_col);
      fwd_data <= line_wdata;
      if (e1v) begin
        for (int i = 0; i < 3; i++) begin
          dw[i][0] <= dw[i][1];
          dw[i][1] <= dw[i][2];
        end
        dw[0][2] <= line[2*DW-1:DW];
        dw[1][2] <= line[DW-1:0];
        dw[2][2] <= e1d;
      end
      e2v <= e1v;
      e2c <= e1c;
      e2r <= e1r;
    end
  end

  always_comb begin
    ctr = dw[1][1];
    case (ctr.dir)
      cdn_pkg::DIR_E: begin
        fwd_mag = dw[1][2].mag;
        bwd_mag = dw[1][0].mag;
      end
      cdn_pkg::DIR_NE: begin
        fwd_mag = dw[0][2].mag;
        bwd_mag = dw[2][0].mag;
      end
      cdn_pkg::DIR_N: begin
        fwd_mag = dw[0][1].mag;
        bwd_mag = dw[2][1].mag;
      end
      default: begin
        fwd_mag = dw[2][2].mag;
        bwd_mag = dw[0][0].mag;
      end
    endcase
    v32   = {1'b0, ctr.mag};
    lo    = {low_thr, 16'b0};
    hi    = {high_thr, 16'b0};
    above = !(v32 < lo);
    res_valid = e2v && (e2c >= CW'(4)) && (e2r >= RW'(4)) &&
                ({1'b0, e2c} < w_eff) && ({1'b0, e2r} < h_eff);
    res_item.column    = cdn_pkg::COL_W'(e2c - CW'(2));
    res_item.row       = cdn_pkg::ROW_W'(e2r - RW'(2));
    res_item.above_low = above;
    res_item.edge_res  = above &&
                         ((v32 > hi) || ((ctr.mag > fwd_mag) && (ctr.mag >= bwd_mag)));
  end

endmodule

// File: rtl/canny_direction_nms_threshold_unit.sv
// ----------------------------------------------------------------------------
// canny_direction_nms_threshold_unit
// Canny direction selection, double threshold and non-maximum suppression.
// ----------------------------------------------------------------------------
// Takes one smoothed Q8.8 pixel per clock in raster order and returns, for
// each interior pixel, its low-threshold and edge bits two rows and two
// columns behind the input. Sustained rate is one pixel per clock while
// out_ready keeps the output register draining. Each of the two line
// stores (pixels and derivatives) is one RAM of MAX_WIDTH entries holding
// two rows per column, read and written back once per pixel, so one port
// pair per RAM sets the rate. Line store contents are undefined after
// reset and need no clearing pass; frame_start restarts the position counters.
module canny_direction_nms_threshold_unit #(
  parameter int MAX_WIDTH  = cdn_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = cdn_pkg::MAX_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  cdn_pkg::in_item_t           in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output cdn_pkg::out_item_t          out_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cdn_pkg::PADDR_W-1:0] paddr,
  input  logic [cdn_pkg::PDATA_W-1:0] pwdata,
  output logic [cdn_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [cdn_pkg::IMGW_W-1:0] image_width;
  logic [cdn_pkg::IMGH_W-1:0] image_height;
  logic [cdn_pkg::THR_W-1:0]  low_threshold;
  logic [cdn_pkg::THR_W-1:0]  high_threshold;
  cdn_pkg::reg_idx_t          reg_idx;

  logic [31:0]   w32, h32;
  logic [CW:0]   w_eff;
  logic [RW:0]   h_eff;

  logic [CW-1:0] column_count, column_count_next;
  logic [RW-1:0] row_count, row_count_next;
  logic [CW-1:0] c_cur;
  logic [RW-1:0] r_cur;

  logic          adv, accept;

  logic                 g_valid;
  logic [CW-1:0]        g_col;
  logic [RW-1:0]        g_row;
  cdn_pkg::deriv_t      g_deriv;
  logic                 res_valid;
  cdn_pkg::out_item_t   res_item;

  assign pready  = 1'b1;
  assign reg_idx = cdn_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= cdn_pkg::WIDTH_RST;
      image_height   <= cdn_pkg::HEIGHT_RST;
      low_threshold  <= cdn_pkg::LOW_RST;
      high_threshold <= cdn_pkg::HIGH_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        cdn_pkg::REG_WIDTH:  image_width    <= pwdata[cdn_pkg::IMGW_W-1:0];
        cdn_pkg::REG_HEIGHT: image_height   <= pwdata[cdn_pkg::IMGH_W-1:0];
        cdn_pkg::REG_LOW:    low_threshold  <= pwdata[cdn_pkg::THR_W-1:0];
        cdn_pkg::REG_HIGH:   high_threshold <= pwdata[cdn_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      cdn_pkg::REG_WIDTH:  prdata = 32'(image_width);
      cdn_pkg::REG_HEIGHT: prdata = 32'(image_height);
      cdn_pkg::REG_LOW:    prdata = 32'(low_threshold);
      cdn_pkg::REG_HIGH:   prdata = 32'(high_threshold);
      default:             prdata = '0;
    endcase
  end

  // clamp frame size to what the line stores and counters support
  always_comb begin
    w32 = 32'(image_width);
    h32 = 32'(image_height);
    if (w32 < 32'(cdn_pkg::MIN_SIZE)) begin
      w32 = 32'(cdn_pkg::MIN_SIZE);
    end else if (w32 > 32'(MAX_WIDTH)) begin
      w32 = 32'(MAX_WIDTH);
    end
    if (h32 < 32'(cdn_pkg::MIN_SIZE)) begin
      h32 = 32'(cdn_pkg::MIN_SIZE);
    end else if (h32 > 32'(MAX_HEIGHT)) begin
      h32 = 32'(MAX_HEIGHT);
    end
    w_eff = (CW+1)'(w32);
    h_eff = (RW+1)'(h32);
  end

  // whole pipeline moves together; output register parts it from the sink
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign accept   = in_valid && adv;

  always_comb begin
    c_cur = in_item.frame_start ? '0 : column_count;
    r_cur = in_item.frame_start ? '0 : row_count;
    if ((CW+1)'(c_cur) + (CW+1)'(1) >= w_eff) begin
      column_count_next = '0;
      row_count_next    = ((RW+1)'(r_cur) + (RW+1)'(1) >= h_eff) ? '0 : r_cur + RW'(1);
    end else begin
      column_count_next = c_cur + CW'(1);
      row_count_next    = r_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  cdn_grad #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_grad (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (accept),
    .in_col    (c_cur),
    .in_row    (r_cur),
    .in_pixel  (in_item.pixel),
    .w_eff     (w_eff),
    .h_eff     (h_eff),
    .out_valid (g_valid),
    .out_col   (g_col),
    .out_row   (g_row),
    .out_deriv (g_deriv)
  );

  cdn_nms #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_nms (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (g_valid),
    .in_col    (g_col),
    .in_row    (g_row),
    .in_deriv  (g_deriv),
    .w_eff     (w_eff),
    .h_eff     (h_eff),
    .low_thr   (low_threshold),
    .high_thr  (high_threshold),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item <= res_item;
    end
  end

endmodule
